// ===== rtl/core/mfre_pkg.sv =====
// Shared types, codes and mask tables for the monochrome framebuffer raster engine.
// No dependencies; imported by mono_framebuffer_raster_engine_top.
`timescale 1ns / 1ps
`default_nettype none

package mfre_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int PAGE_W      = 3;
  localparam int BIT_TOP     = 7;

  // Parameter defaults
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  typedef enum logic [2:0] {
    ACT_PIXEL = 3'd0,
    ACT_HRUN  = 3'd1,
    ACT_VRUN  = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_READ  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    COL_SET    = 2'd0,
    COL_CLEAR  = 2'd1,
    COL_INVERT = 2'd2,
    COL_NONE   = 2'd3
  } color_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_WRITE,
    ST_RESP
  } state_t;

  // Top n bits of a byte set
  localparam logic [7:0] HIGH_MASK [8] = '{
    8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE
  };

  // Low n bits of a byte set
  localparam logic [7:0] LOW_MASK [8] = '{
    8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F
  };

  localparam logic [7:0] FULL_BYTE = 8'hFF;

endpackage

// ===== rtl/core/mono_framebuffer_raster_engine_top.sv =====
// Top level of the monochrome framebuffer raster engine: command decode, run clipping,
// read-modify-write sequencer and the 1024-byte frame store. Depends on mfre_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken on a clock edge with start high and busy low. A drawing request
// runs through a single read-modify-write loop on the frame store, reading then writing
// back each byte in turn, so its cost is set by that memory port pair. Steps per action:
//   pixel                 : decode, read, write, back to idle
//   horizontal run of n   : decode, then n bytes, n = clipped width (one byte per column)
//   vertical run over p   : decode, then p bytes, p = pages touched (at most 8)
//   read byte             : decode, respond; off-screen reads answer from decode
//   clear all             : decode, then all 1024 bytes, one byte per cycle
//   empty, clipped away, color "no effect", unused action : decode, back to idle
// After reset the block runs a clearing pass over all 1024 bytes with busy high; mirror
// writes are taken during it. A read answers with read_valid high for exactly one
// cycle together with read_data; the receiver cannot stall, so capture it then.
// mirror_mode is written over the cfg channel (cfg_ready is always high) and must
// only change while busy is low.
module mono_framebuffer_raster_engine_top
  import mfre_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  wire                clk,
  input  wire                rst,
  // command channel
  input  wire                start,
  output logic               busy,
  input  wire  [2:0]         action,
  input  wire  signed [15:0] x,
  input  wire  signed [15:0] y,
  input  wire  signed [15:0] run_length,
  input  wire  [1:0]         color,
  input  wire  [2:0]         page,
  // result
  output logic               read_valid,
  output logic [7:0]         read_data,
  // configuration
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire                cfg_data
);

  localparam int COL_W      = $clog2(SCREEN_WIDTH + 1);
  localparam int SUM_W      = (COL_W + PAGE_W > ADDR_W) ? COL_W + PAGE_W : ADDR_W;
  localparam int PAGE_COUNT = SCREEN_HEIGHT / 8;
  localparam logic signed [17:0] WIDTH_S  = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] HEIGHT_S = 18'(SCREEN_HEIGHT);
  localparam logic [PAGE_W:0]    PAGE_COUNT_V = PAGE_COUNT[PAGE_W:0];
  localparam logic [PAGE_W-1:0]  PAGE_LAST    = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [SUM_W-1:0]   WIDTH_SUM    = SUM_W'(SCREEN_WIDTH);

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [COL_W-1:0] col,
                                                  input logic [PAGE_W-1:0] pg);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(col) + SUM_W'(pg) * WIDTH_SUM;
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [7:0] bit_rev(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[BIT_TOP - i];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic               mirror_mode;
  logic [ADDR_W-1:0]  clr_addr;

  // latched request
  logic [2:0]         req_action;
  logic signed [15:0] req_x;
  logic signed [15:0] req_y;
  logic signed [15:0] req_len;
  logic [1:0]         req_color;
  logic [2:0]         req_page;

  // draw loop registers
  logic               is_v;
  logic               at_first;
  logic [COL_W-1:0]   cur;
  logic [COL_W-1:0]   last;
  logic [COL_W-1:0]   fix_col;
  logic [PAGE_W-1:0]  fix_pg;
  logic [2:0]         lo_bit;
  logic [2:0]         hi_bit;

  // frame store
  logic [7:0]         mem [STORE_DEPTH];
  logic [7:0]         mem_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [7:0]         mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Clipping, done from the latched request during ST_PREP
  // ---------------------------------------------------------------------------
  logic signed [17:0] x_s, y_s, len_s, len_h;
  logic signed [17:0] start_h, end_raw_h, end_h, last_h;
  logic signed [17:0] top_v, end_raw_v, end_v, bot_v;
  logic               h_ok, v_ok, rd_ok, paint_on;
  logic [PAGE_W-1:0]  src_pg;
  logic [ADDR_W-1:0]  rd_addr;

  always_comb begin
    x_s   = 18'(req_x);
    y_s   = 18'(req_y);
    len_s = 18'(req_len);
    // a pixel is a horizontal run of one
    len_h = (req_action == ACT_PIXEL) ? 18'sd1 : len_s;

    start_h   = (x_s < 0) ? 18'sd0 : x_s;
    end_raw_h = x_s + len_h;
    end_h     = (end_raw_h > WIDTH_S) ? WIDTH_S : end_raw_h;
    last_h    = end_h - 18'sd1;
    h_ok      = (y_s >= 0) && (y_s < HEIGHT_S) && (end_h > start_h);

    top_v     = (y_s < 0) ? 18'sd0 : y_s;
    end_raw_v = y_s + len_s;
    end_v     = (end_raw_v > HEIGHT_S) ? HEIGHT_S : end_raw_v;
    bot_v     = end_v - 18'sd1;
    v_ok      = (x_s >= 0) && (x_s < WIDTH_S) && (end_v > top_v);

    paint_on  = (req_color != COL_NONE);

    rd_ok   = (x_s >= 0) && (x_s < WIDTH_S) && ({1'b0, req_page} < PAGE_COUNT_V);
    src_pg  = mirror_mode ? (PAGE_LAST - req_page) : req_page;
    rd_addr = byte_addr(x_s[COL_W-1:0], src_pg);
  end

  // ---------------------------------------------------------------------------
  // Per-byte address and mask of the draw loop
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]  step_col;
  logic [PAGE_W-1:0] step_pg;
  logic [ADDR_W-1:0] step_addr;
  logic [2:0]        lo_eff, hi_eff;
  logic [7:0]        mask;
  logic [7:0]        painted;

  always_comb begin
    step_col  = is_v ? fix_col : cur;
    step_pg   = is_v ? cur[PAGE_W-1:0] : fix_pg;
    step_addr = byte_addr(step_col, step_pg);
    // partial masks only at the top and bottom page of a vertical run
    lo_eff    = (!is_v || at_first)    ? lo_bit : 3'd0;
    hi_eff    = (!is_v || cur == last) ? hi_bit : 3'(BIT_TOP);
    mask      = ~LOW_MASK[lo_eff] & ~HIGH_MASK[3'(BIT_TOP) - hi_eff];
    unique case (req_color)
      COL_SET:    painted = mem_q | mask;
      COL_CLEAR:  painted = mem_q & ~mask;
      COL_INVERT: painted = mem_q ^ mask;
      COL_NONE:   painted = mem_q;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_PREP;
      ST_PREP: begin
        unique case (req_action)
          ACT_PIXEL, ACT_HRUN: state_next = (h_ok && paint_on) ? ST_READ : ST_IDLE;
          ACT_VRUN:            state_next = (v_ok && paint_on) ? ST_READ : ST_IDLE;
          ACT_CLEAR:           state_next = ST_CLEAR;
          ACT_READ:            state_next = rd_ok ? ST_RESP : ST_IDLE;
          default:             state_next = ST_IDLE;
        endcase
      end
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: state_next = (cur == last) ? ST_IDLE : ST_READ;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory port controls
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = step_addr;
    mem_wdata = painted;
    mem_raddr = step_addr;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_PREP:  mem_raddr = rd_addr;
      ST_WRITE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      mirror_mode <= 1'b0;
      read_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      // answer an off-screen read with zero right away, an on-screen one after RESP
      read_valid <= (state == ST_RESP) ||
                    (state == ST_PREP && req_action == ACT_READ && !rd_ok);
      if (cfg_valid && cfg_ready) begin
        mirror_mode <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_PREP && req_action == ACT_CLEAR) begin
        clr_addr <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_action <= action;
      req_x      <= x;
      req_y      <= y;
      req_len    <= run_length;
      req_color  <= color;
      req_page   <= page;
    end

    if (state == ST_PREP) begin
      at_first <= 1'b1;
      if (req_action == ACT_VRUN) begin
        is_v    <= 1'b1;
        cur     <= COL_W'(top_v[5:3]);
        last    <= COL_W'(bot_v[5:3]);
        fix_col <= x_s[COL_W-1:0];
        fix_pg  <= '0;
        lo_bit  <= top_v[2:0];
        hi_bit  <= bot_v[2:0];
      end else begin
        is_v    <= 1'b0;
        cur     <= start_h[COL_W-1:0];
        last    <= last_h[COL_W-1:0];
        fix_col <= '0;
        fix_pg  <= y_s[5:3];
        lo_bit  <= y_s[2:0];
        hi_bit  <= y_s[2:0];
      end
    end

    // advance to the next column or page after each write-back
    if (state == ST_WRITE) begin
      at_first <= 1'b0;
      cur      <= cur + 1'b1;
    end

    if (state == ST_PREP && req_action == ACT_READ && !rd_ok) begin
      read_data <= '0;
    end
    if (state == ST_RESP) begin
      read_data <= mirror_mode ? bit_rev(mem_q) : mem_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mfre_checker.sv =====
// Port-level checks of the monochrome framebuffer raster engine, bound to its top level.
// Depends on mono_framebuffer_raster_engine_top.
`timescale 1ns / 1ps
`default_nettype none

module mfre_checker (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire read_valid,
  input wire cfg_valid,
  input wire cfg_ready
);

  // reset starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // a taken request always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  // a result finishes its request: it comes out of a busy cycle and leaves the block idle
  a_result_ends: assert property (@(posedge clk) disable iff (rst)
    read_valid |-> (!busy && $past(busy)))
    else $error("result outside request completion");

  // one result per request
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    read_valid |=> !read_valid)
    else $error("result repeated");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind mono_framebuffer_raster_engine_top mfre_checker u_mfre_checker (.*);

`default_nettype wire
